FILE: design/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants for the I2C bit-level master line sequencer.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int CFG_IDX_W     = 8;

    // Command codes carried in the mode field
    localparam logic [2:0] MODE_NONE     = 3'd0;
    localparam logic [2:0] MODE_START    = 3'd1;
    localparam logic [2:0] MODE_STOP     = 3'd2;
    localparam logic [2:0] MODE_WRITE    = 3'd3;
    localparam logic [2:0] MODE_READ     = 3'd4;
    localparam logic [2:0] MODE_WAIT_ACK = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETUP_TICKS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT_TICKS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_SETTLE_TICKS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT      = 8'd3;

    // Reset values of the timing registers
    localparam logic [7:0] SETUP_TICKS_RST      = 8'd4;
    localparam logic [7:0] HALF_BIT_TICKS_RST   = 8'd2;
    localparam logic [7:0] ACK_SETTLE_TICKS_RST = 8'd1;
    localparam logic [7:0] ACK_TIMEOUT_RST      = 8'd250;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_level;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_drive;
        logic       sda_output_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_missing;
    } res_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           wdata;
    } cfg_item_t;

    typedef struct packed {
        logic [7:0] setup_ticks;
        logic [7:0] half_bit_ticks;
        logic [7:0] ack_settle_ticks;
        logic [7:0] ack_timeout;
    } timing_t;

endpackage

FILE: design/i2cbm_channels.sv
// ----------------------------------------------------------------------------
// i2cbm channels
// Valid/ready channel interfaces for commands, results and configuration.
// ----------------------------------------------------------------------------
interface i2cbm_cmd_if;
    logic                 valid;
    logic                 ready;
    i2cbm_pkg::cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cbm_res_if;
    logic                 valid;
    logic                 ready;
    i2cbm_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cbm_cfg_if;
    logic                 valid;
    logic                 ready;
    i2cbm_pkg::cfg_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/i2c_bit_level_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master_unit
// I2C master line sequencer: one timing tick in, one line/status result out.
// ----------------------------------------------------------------------------
// Each command transaction is one timing tick and gives exactly one result
// transaction. The unit takes one tick per clock: a tick is captured in the
// input register and, once the result register is free, evaluated by the
// sequencer and written to the result register, so ticks may follow back
// to back. The only limit on the rate is the result side: while a result
// waits in the output register and the sink is stalled, the input register
// holds one more tick, then ready drops. A command in mode is taken only on
// a tick where the sequencer is idle; otherwise it is ignored. Timing
// registers are written through the cfg channel (always ready) and must
// only change while the unit is idle.
module i2c_bit_level_master_unit (
    input  logic        clk,
    input  logic        rst_n,
    i2cbm_cmd_if.sink   cmd,
    i2cbm_res_if.source res,
    i2cbm_cfg_if.sink   cfg
);

    i2cbm_pkg::cmd_item_t cmd_reg;
    logic                 cmd_valid_reg;
    i2cbm_pkg::res_item_t res_reg;
    logic                 res_valid_reg;
    i2cbm_pkg::res_item_t seq_res;
    i2cbm_pkg::timing_t   timing;
    logic                 res_free;
    logic                 step;

    // Advance the sequencer whenever a held tick can move into the result slot
    assign res_free  = !res_valid_reg || res.ready;
    assign step      = cmd_valid_reg && res_free;
    assign cmd.ready = !cmd_valid_reg || res_free;
    assign cfg.ready = 1'b1;

    i2cbm_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cfg.valid),
        .wr     (cfg.data),
        .timing (timing)
    );

    i2cbm_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (step),
        .item   (cmd_reg),
        .timing (timing),
        .res    (seq_res)
    );

    // Input register: hold the tick until the sequencer consumes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            cmd_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            cmd_reg <= cmd.data;
        end
    end

    // Result register: drop valid once the sink takes the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= seq_res;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

endmodule

FILE: design/i2cbm_cfg.sv
// ----------------------------------------------------------------------------
// i2cbm_cfg
// Timing register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module i2cbm_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  i2cbm_pkg::cfg_item_t wr,
    output i2cbm_pkg::timing_t   timing
);

    i2cbm_pkg::timing_t timing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.setup_ticks      <= i2cbm_pkg::SETUP_TICKS_RST;
            timing_reg.half_bit_ticks   <= i2cbm_pkg::HALF_BIT_TICKS_RST;
            timing_reg.ack_settle_ticks <= i2cbm_pkg::ACK_SETTLE_TICKS_RST;
            timing_reg.ack_timeout      <= i2cbm_pkg::ACK_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr.index)
                i2cbm_pkg::REG_SETUP_TICKS:      timing_reg.setup_ticks      <= wr.wdata;
                i2cbm_pkg::REG_HALF_BIT_TICKS:   timing_reg.half_bit_ticks   <= wr.wdata;
                i2cbm_pkg::REG_ACK_SETTLE_TICKS: timing_reg.ack_settle_ticks <= wr.wdata;
                i2cbm_pkg::REG_ACK_TIMEOUT:      timing_reg.ack_timeout      <= wr.wdata;
                default:                         ;
            endcase
        end
    end

    assign timing = timing_reg;

endmodule

FILE: design/i2cbm_seq.sv
// ----------------------------------------------------------------------------
// i2cbm_seq
// Line sequencer state and the per-tick next-state logic.
// ----------------------------------------------------------------------------
module i2cbm_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  i2cbm_pkg::cmd_item_t item,
    input  i2cbm_pkg::timing_t   timing,
    output i2cbm_pkg::res_item_t res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_ST_A    = 4'd1;
    localparam logic [3:0] PH_ST_B    = 4'd2;
    localparam logic [3:0] PH_SP_A    = 4'd3;
    localparam logic [3:0] PH_SP_B    = 4'd4;
    localparam logic [3:0] PH_WR_LO   = 4'd5;
    localparam logic [3:0] PH_WR_HI   = 4'd6;
    localparam logic [3:0] PH_RD_LO   = 4'd7;
    localparam logic [3:0] PH_RD_HI   = 4'd8;
    localparam logic [3:0] PH_AK_LO   = 4'd9;
    localparam logic [3:0] PH_AK_HI   = 4'd10;
    localparam logic [3:0] PH_WA_REL  = 4'd11;
    localparam logic [3:0] PH_WA_HI   = 4'd12;
    localparam logic [3:0] PH_WA_POLL = 4'd13;

    localparam logic [3:0] BIT_LAST = 4'(i2cbm_pkg::BITS_PER_BYTE);

    logic [3:0] phase_reg, phase_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] rx_reg, rx_next;
    logic [7:0] poll_reg, poll_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       oe_reg, oe_next;
    logic       nack_reg, nack_next;
    logic       fail_reg, fail_next;
    logic       done_now, miss_now;
    logic [7:0] seg_len;
    logic [3:0] bit_inc;
    logic [7:0] shift_in;

    always_comb
    begin
        unique case (phase_reg)
            PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: seg_len = timing.setup_ticks;
            PH_WA_REL, PH_WA_HI:                seg_len = timing.ack_settle_ticks;
            default:                            seg_len = timing.half_bit_ticks;
        endcase
    end

    assign bit_inc  = bit_reg + 4'd1;
    assign shift_in = {shift_reg[6:0], item.sda_level};

    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        rx_next    = rx_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        oe_next    = oe_reg;
        nack_next  = nack_reg;
        fail_next  = fail_reg;
        done_now   = 1'b0;
        miss_now   = 1'b0;

        if (phase_reg == PH_IDLE)
        begin
            unique case (item.mode)
                i2cbm_pkg::MODE_START:
                begin
                    scl_next = 1'b1; sda_next = 1'b1; oe_next = 1'b1;
                    phase_next = PH_ST_A; tick_next = 8'd1;
                end
                i2cbm_pkg::MODE_STOP:
                begin
                    fail_next = 1'b0;
                    scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
                    phase_next = PH_SP_A; tick_next = 8'd1;
                end
                i2cbm_pkg::MODE_WRITE:
                begin
                    oe_next = 1'b1; scl_next = 1'b0;
                    bit_next = 4'd0;
                    // drive the MSB now and keep the rest queued
                    sda_next   = item.tx_byte[7];
                    shift_next = {item.tx_byte[6:0], 1'b0};
                    phase_next = PH_WR_LO; tick_next = 8'd1;
                end
                i2cbm_pkg::MODE_READ:
                begin
                    oe_next = 1'b0; sda_next = 1'b1; scl_next = 1'b0;
                    shift_next = 8'd0; bit_next = 4'd0;
                    nack_next  = item.send_nack;
                    phase_next = PH_RD_LO; tick_next = 8'd1;
                end
                i2cbm_pkg::MODE_WAIT_ACK:
                begin
                    oe_next = 1'b0; sda_next = 1'b1;
                    phase_next = PH_WA_REL; tick_next = 8'd1;
                end
                default: ;
            endcase
        end
        else if (phase_reg == PH_WA_POLL)
        begin
            priority if (!item.sda_level)
            begin
                scl_next = 1'b0;
                phase_next = PH_IDLE; tick_next = 8'd0; done_now = 1'b1;
            end
            else if (poll_reg >= timing.ack_timeout)
            begin
                // give up: flag the miss and close the bus with a stop
                fail_next = 1'b1;
                scl_next = 1'b0; sda_next = 1'b0; oe_next = 1'b1;
                phase_next = PH_SP_A; tick_next = 8'd1;
            end
            else
            begin
                poll_next = poll_reg + 8'd1;
            end
        end
        else if (tick_reg < seg_len)
        begin
            tick_next = tick_reg + 8'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_ST_A:
                begin
                    sda_next = 1'b0; phase_next = PH_ST_B; tick_next = 8'd1;
                end
                PH_ST_B:
                begin
                    scl_next = 1'b0;
                    phase_next = PH_IDLE; tick_next = 8'd0; done_now = 1'b1;
                end
                PH_SP_A:
                begin
                    sda_next = 1'b1; scl_next = 1'b1;
                    phase_next = PH_SP_B; tick_next = 8'd1;
                end
                PH_SP_B:
                begin
                    phase_next = PH_IDLE; tick_next = 8'd0; done_now = 1'b1;
                    miss_now = fail_reg; fail_next = 1'b0;
                end
                PH_WR_LO:
                begin
                    scl_next = 1'b1; phase_next = PH_WR_HI; tick_next = 8'd1;
                end
                PH_WR_HI:
                begin
                    scl_next = 1'b0;
                    bit_next = bit_inc;
                    if (bit_inc >= BIT_LAST)
                    begin
                        phase_next = PH_IDLE; tick_next = 8'd0; done_now = 1'b1;
                    end
                    else
                    begin
                        sda_next   = shift_reg[7];
                        shift_next = {shift_reg[6:0], 1'b0};
                        phase_next = PH_WR_LO; tick_next = 8'd1;
                    end
                end
                PH_RD_LO:
                begin
                    scl_next = 1'b1; phase_next = PH_RD_HI; tick_next = 8'd1;
                end
                PH_RD_HI:
                begin
                    shift_next = shift_in;
                    bit_next   = bit_inc;
                    scl_next   = 1'b0;
                    tick_next  = 8'd1;
                    if (bit_inc >= BIT_LAST)
                    begin
                        rx_next = shift_in;
                        oe_next = 1'b1;
                        sda_next = nack_reg;
                        phase_next = PH_AK_LO;
                    end
                    else
                    begin
                        phase_next = PH_RD_LO;
                    end
                end
                PH_AK_LO:
                begin
                    scl_next = 1'b1; phase_next = PH_AK_HI; tick_next = 8'd1;
                end
                PH_AK_HI:
                begin
                    scl_next = 1'b0;
                    phase_next = PH_IDLE; tick_next = 8'd0; done_now = 1'b1;
                end
                PH_WA_REL:
                begin
                    scl_next = 1'b1; phase_next = PH_WA_HI; tick_next = 8'd1;
                end
                PH_WA_HI:
                begin
                    poll_next = 8'd0; phase_next = PH_WA_POLL; tick_next = 8'd0;
                end
                default:
                begin
                    phase_next = PH_IDLE; tick_next = 8'd0; done_now = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 8'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            rx_reg    <= 8'd0;
            poll_reg  <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            oe_reg    <= 1'b1;
            nack_reg  <= 1'b0;
            fail_reg  <= 1'b0;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            rx_reg    <= rx_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            oe_reg    <= oe_next;
            nack_reg  <= nack_next;
            fail_reg  <= fail_next;
        end
    end

    always_comb
    begin
        res.scl_level         = scl_next;
        res.sda_drive         = oe_next ? sda_next : 1'b1;
        res.sda_output_enable = oe_next;
        res.busy_res          = (phase_next != PH_IDLE);
        res.done_res          = done_now;
        res.rx_byte           = rx_next;
        res.ack_missing       = miss_now;
    end

endmodule
